// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the lexer back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock outside reset
`define AET_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// consequence checked in the cycle after the antecedent
`define AET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/aet_pkg.sv =====
// types, codes and constants of the expression lexer
package aet_pkg;

    localparam int MAX_DIGITS      = 18;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int KIND_W = 4;
    localparam int MANT_W = 60;
    localparam int EXP_W  = 8;
    localparam int SIG_W  = 5;
    localparam int POW_W  = 5;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // binding powers in tenths
    localparam logic [POW_W-1:0] POW_ADD_L = 5'd10;
    localparam logic [POW_W-1:0] POW_ADD_R = 5'd11;
    localparam logic [POW_W-1:0] POW_MUL_L = 5'd20;
    localparam logic [POW_W-1:0] POW_MUL_R = 5'd21;

    typedef enum logic [KIND_W-1:0] {
        TK_EOF     = 4'd0,
        TK_NUMBER  = 4'd1,
        TK_PLUS    = 4'd2,
        TK_MINUS   = 4'd3,
        TK_MUL     = 4'd4,
        TK_DIV     = 4'd5,
        TK_LPAREN  = 4'd6,
        TK_RPAREN  = 4'd7,
        TK_INVALID = 4'd8
    } t_kind;

    typedef enum logic [3:0] {
        CL_DIGIT,
        CL_DOT,
        CL_SPACE,
        CL_NUL,
        CL_PLUS,
        CL_MINUS,
        CL_MUL,
        CL_DIV,
        CL_LPAREN,
        CL_RPAREN,
        CL_OTHER
    } t_char_class;

    typedef struct packed {
        t_char_class cls;
        logic [3:0]  digit;
    } t_char_item;

    typedef struct packed {
        t_kind                    kind;
        logic [MANT_W-1:0]        mantissa;
        logic signed [EXP_W-1:0]  dec_exponent;
        logic                     inexact;
        logic [POW_W-1:0]         left_power;
        logic [POW_W-1:0]         right_power;
        logic                     last;
    } t_token;

endpackage

// ===== hw/rtl/aet_front.sv =====
// character classifier of the lexer front end
module aet_front (
    input  logic [7:0]          i_char_code,
    output aet_pkg::t_char_item o_item
);
    import aet_pkg::*;

    always_comb begin
        o_item.digit = 4'(i_char_code - CH_ZERO);
        if (i_char_code >= CH_ZERO && i_char_code <= CH_NINE) begin
            o_item.cls = CL_DIGIT;
        end else begin
            unique case (i_char_code)
                CH_NUL:    o_item.cls = CL_NUL;
                CH_SPACE:  o_item.cls = CL_SPACE;
                CH_DOT:    o_item.cls = CL_DOT;
                CH_PLUS:   o_item.cls = CL_PLUS;
                CH_MINUS:  o_item.cls = CL_MINUS;
                CH_STAR:   o_item.cls = CL_MUL;
                CH_SLASH:  o_item.cls = CL_DIV;
                CH_LPAREN: o_item.cls = CL_LPAREN;
                CH_RPAREN: o_item.cls = CL_RPAREN;
                default:   o_item.cls = CL_OTHER;
            endcase
        end
    end

endmodule

// ===== hw/rtl/aet_fifo.sv =====
// small register fifo between lexer front and back
module aet_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/aet_back.sv =====
// lexer back end: number collection, token build and two-entry output buffer
`include "assert_macros.svh"

module aet_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  aet_pkg::t_char_item   i_item,
    input  logic                  i_item_valid,
    output logic                  o_item_pop,
    output aet_pkg::t_token       o_token,
    output logic                  o_out_valid,
    input  logic                  i_out_ready
);
    import aet_pkg::*;

    // lexer state
    logic                    r_in_number, n_in_number;
    logic                    r_seen_dot, n_seen_dot;
    logic                    r_halted, n_halted;
    logic                    r_ignore, n_ignore;
    logic [MANT_W-1:0]       r_mant, n_mant;
    logic [SIG_W-1:0]        r_sig, n_sig;
    logic signed [EXP_W-1:0] r_exp, n_exp;
    logic                    r_inexact, n_inexact;

    // output buffer
    t_token     r_slot0, n_slot0;
    t_token     r_slot1, n_slot1;
    logic [1:0] r_cnt, n_cnt;

    logic                    is_digit, is_dot, is_space;
    logic                    w_has_num, w_has_op;
    logic [1:0]              need;
    logic                    pop_out, fits, process;
    logic [1:0]              base;
    logic [MANT_W-1:0]       mul10;
    logic signed [EXP_W:0]   exp_up, exp_dn;
    logic [MANT_W-1:0]       td_mant;
    logic [SIG_W-1:0]        td_sig;
    logic signed [EXP_W-1:0] td_exp;
    logic                    td_inexact;
    t_token                  num_tok, op_tok, tok0, tok1;

    assign is_digit = (i_item.cls == CL_DIGIT);
    assign is_dot   = (i_item.cls == CL_DOT);
    assign is_space = (i_item.cls == CL_SPACE);

    // a char that ends a number yields the number word first
    assign w_has_num = !r_ignore && r_in_number && !is_digit && !is_dot;
    assign w_has_op  = !r_ignore && !is_digit && !is_space && !(r_in_number && is_dot);
    assign need      = {1'b0, w_has_num} + {1'b0, w_has_op};

    assign pop_out    = o_out_valid && i_out_ready;
    assign fits       = ({1'b0, r_cnt} - {2'b0, pop_out} + {1'b0, need}) <= 3'd2;
    assign process    = i_item_valid && fits;
    assign o_item_pop = process;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_token     = r_slot0;

    // one digit into the accumulator
    always_comb begin
        mul10      = (r_mant << 3) + (r_mant << 1) + MANT_W'(i_item.digit);
        exp_up     = {r_exp[EXP_W-1], r_exp} + 9'sd1;
        exp_dn     = {r_exp[EXP_W-1], r_exp} - 9'sd1;
        td_mant    = r_mant;
        td_sig     = r_sig;
        td_exp     = r_exp;
        td_inexact = r_inexact;
        if (!r_halted) begin
            if (r_sig < SIG_W'(MAX_DIGITS)) begin
                td_mant = mul10;
                if (mul10 != '0) begin
                    td_sig = r_sig + 1'b1;
                end
                if (r_seen_dot) begin
                    if (exp_dn < -9'sd128) begin
                        td_exp     = -8'sd128;
                        td_inexact = 1'b1;
                    end else begin
                        td_exp = exp_dn[EXP_W-1:0];
                    end
                end
            end else begin
                if (i_item.digit != 4'd0) begin
                    td_inexact = 1'b1;
                end
                if (!r_seen_dot) begin
                    if (exp_up > 9'sd127) begin
                        td_exp     = 8'sd127;
                        td_inexact = 1'b1;
                    end else begin
                        td_exp = exp_up[EXP_W-1:0];
                    end
                end
            end
        end
    end

    // token build
    always_comb begin
        num_tok              = '0;
        num_tok.kind         = TK_NUMBER;
        num_tok.mantissa     = r_mant;
        num_tok.dec_exponent = r_exp;
        num_tok.inexact      = r_inexact;

        op_tok      = '0;
        op_tok.last = 1'b1;
        unique case (i_item.cls)
            CL_NUL:    op_tok.kind = TK_EOF;
            CL_PLUS:   op_tok.kind = TK_PLUS;
            CL_MINUS:  op_tok.kind = TK_MINUS;
            CL_MUL:    op_tok.kind = TK_MUL;
            CL_DIV:    op_tok.kind = TK_DIV;
            CL_LPAREN: op_tok.kind = TK_LPAREN;
            CL_RPAREN: op_tok.kind = TK_RPAREN;
            default:   op_tok.kind = TK_INVALID;
        endcase
        if (i_item.cls == CL_PLUS || i_item.cls == CL_MINUS) begin
            op_tok.left_power  = POW_ADD_L;
            op_tok.right_power = POW_ADD_R;
        end else if (i_item.cls == CL_MUL || i_item.cls == CL_DIV) begin
            op_tok.left_power  = POW_MUL_L;
            op_tok.right_power = POW_MUL_R;
        end

        tok0      = w_has_num ? num_tok : op_tok;
        tok0.last = !(w_has_num && w_has_op);
        tok1      = op_tok;
    end

    // next lexer state
    always_comb begin
        n_in_number = r_in_number;
        n_seen_dot  = r_seen_dot;
        n_halted    = r_halted;
        n_ignore    = r_ignore;
        n_mant      = r_mant;
        n_sig       = r_sig;
        n_exp       = r_exp;
        n_inexact   = r_inexact;
        if (process) begin
            if (r_ignore) begin
                if (i_item.cls == CL_NUL) begin
                    n_ignore = 1'b0;
                end
            end else if (r_in_number && is_digit) begin
                n_mant    = td_mant;
                n_sig     = td_sig;
                n_exp     = td_exp;
                n_inexact = td_inexact;
            end else if (r_in_number && is_dot) begin
                if (r_seen_dot) begin
                    n_halted = 1'b1;
                end else begin
                    n_seen_dot = 1'b1;
                end
            end else begin
                if (w_has_num) begin
                    n_in_number = 1'b0;
                    n_seen_dot  = 1'b0;
                    n_halted    = 1'b0;
                    n_mant      = '0;
                    n_sig       = '0;
                    n_exp       = '0;
                    n_inexact   = 1'b0;
                end
                // number state is clear here, so the digit starts fresh
                if (is_digit) begin
                    n_in_number = 1'b1;
                    n_mant      = td_mant;
                    n_sig       = td_sig;
                    n_exp       = td_exp;
                    n_inexact   = td_inexact;
                end
                if (op_tok.kind == TK_INVALID && w_has_op) begin
                    n_ignore = 1'b1;
                end
            end
        end
    end

    // output buffer: shift on pop, append new words behind the survivors
    always_comb begin
        n_slot0 = pop_out ? r_slot1 : r_slot0;
        n_slot1 = r_slot1;
        base    = r_cnt - {1'b0, pop_out};
        n_cnt   = base;
        if (process && need != 2'd0) begin
            if (base == 2'd0) begin
                n_slot0 = tok0;
            end else begin
                n_slot1 = tok0;
            end
            if (need == 2'd2) begin
                n_slot1 = tok1;
            end
            n_cnt = base + need;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_number <= 1'b0;
            r_seen_dot  <= 1'b0;
            r_halted    <= 1'b0;
            r_ignore    <= 1'b0;
            r_mant      <= '0;
            r_sig       <= '0;
            r_exp       <= '0;
            r_inexact   <= 1'b0;
            r_cnt       <= 2'd0;
        end else begin
            r_in_number <= n_in_number;
            r_seen_dot  <= n_seen_dot;
            r_halted    <= n_halted;
            r_ignore    <= n_ignore;
            r_mant      <= n_mant;
            r_sig       <= n_sig;
            r_exp       <= n_exp;
            r_inexact   <= n_inexact;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    `AET_ASSERT(a_ignore_no_number, r_ignore |-> !r_in_number, "number open while ignoring")
    `AET_ASSERT(a_halt_needs_dot, r_halted |-> (r_seen_dot && r_in_number), "halt without dot")
    `AET_ASSERT(a_idle_clear, !r_in_number |-> ({r_mant, r_sig, r_exp} == '0), "stale number")
    `AET_ASSERT(a_buffer_bound, 1'b1 |-> (r_cnt != 2'd3), "output buffer overfilled")
    `AET_ASSERT_NEXT(a_number_closed, process && w_has_num, !r_in_number, "number not closed")

endmodule

// ===== hw/rtl/arith_expression_tokenizer.sv =====
// top level of the arithmetic expression lexer
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+-------------------------------------------
//  char in | i_in_valid   | o_in_ready   | i_char_code
//  token   | o_out_valid  | i_out_ready  | o_token_kind .. o_last (one word per token)
//
// one character a cycle sustained while the output buffer has room; a character that
// closes a number and is itself an operator, paren, nul or bad char yields two words,
// sent in turn. first word is valid once its char passes the queue and output buffer.
// the char queue (QUEUE_DEPTH entries) lets input run on while the token side stalls.
// reset is synchronous and clears all control state; no clearing pass is needed.
module arith_expression_tokenizer #(
    parameter int QUEUE_DEPTH = aet_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_char_code,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [aet_pkg::KIND_W-1:0]         o_token_kind,
    output logic [aet_pkg::MANT_W-1:0]         o_mantissa,
    output logic signed [aet_pkg::EXP_W-1:0]   o_dec_exponent,
    output logic                               o_inexact,
    output logic [aet_pkg::POW_W-1:0]          o_left_power,
    output logic [aet_pkg::POW_W-1:0]          o_right_power,
    output logic                               o_last
);
    import aet_pkg::*;

    t_char_item front_item;
    t_char_item queue_item;
    logic       queue_full;
    logic       queue_valid;
    logic       queue_pop;
    t_token     token;

    aet_front u_front (
        .i_char_code (i_char_code),
        .o_item      (front_item)
    );

    aet_fifo #(
        .WIDTH ($bits(t_char_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (front_item),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_item)
    );

    assign o_in_ready = !queue_full;

    aet_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (queue_item),
        .i_item_valid (queue_valid),
        .o_item_pop   (queue_pop),
        .o_token      (token),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready)
    );

    assign o_token_kind   = token.kind;
    assign o_mantissa     = token.mantissa;
    assign o_dec_exponent = token.dec_exponent;
    assign o_inexact      = token.inexact;
    assign o_left_power   = token.left_power;
    assign o_right_power  = token.right_power;
    assign o_last         = token.last;

endmodule

// ===== test/arith_expression_tokenizer_checker.sv =====
// token checker for the expression lexer: predicts tokens from accepted chars and compares
`timescale 1ns / 100ps

module arith_expression_tokenizer_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [7:0]                         i_char_code,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [aet_pkg::KIND_W-1:0]         i_token_kind,
    input  logic [aet_pkg::MANT_W-1:0]         i_mantissa,
    input  logic signed [aet_pkg::EXP_W-1:0]   i_dec_exponent,
    input  logic                               i_inexact,
    input  logic [aet_pkg::POW_W-1:0]          i_left_power,
    input  logic [aet_pkg::POW_W-1:0]          i_right_power,
    input  logic                               i_last,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import aet_pkg::*;

    t_token tokens_due[$];
    int     tokens_seen;

    // lexer state as predicted
    logic              num_active;
    logic              dot_seen;
    logic              frac_frozen;
    logic              skip_to_nul;
    logic              num_inexact;
    logic [MANT_W-1:0] num_mant;
    logic [SIG_W-1:0]  num_sig;
    int                num_exp;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: token %0d %s: got %0h, expected %0h",
                 $realtime, tokens_seen, what, got, want);
        o_fail_count++;
    endtask

    task automatic clear_number();
        num_active  = 1'b0;
        dot_seen    = 1'b0;
        frac_frozen = 1'b0;
        num_inexact = 1'b0;
        num_mant    = '0;
        num_sig     = '0;
        num_exp     = 0;
    endtask

    task automatic shift_exponent(input int delta);
        num_exp = num_exp + delta;
        if (num_exp > 127) begin
            num_exp     = 127;
            num_inexact = 1'b1;
        end
        if (num_exp < -128) begin
            num_exp     = -128;
            num_inexact = 1'b1;
        end
    endtask

    task automatic add_digit(input logic [3:0] d);
        if (!frac_frozen) begin
            if (num_sig < MAX_DIGITS) begin
                num_mant = num_mant * 10 + MANT_W'(d);
                // leading zeros do not count as significant
                if (num_mant != 0) num_sig++;
                if (dot_seen) shift_exponent(-1);
            end else begin
                if (d != 0) num_inexact = 1'b1;
                if (!dot_seen) shift_exponent(1);
            end
        end
    endtask

    task automatic lex_char(input logic [7:0] c);
        t_token toks[$];
        t_token tk;
        logic   is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (skip_to_nul) begin
            if (c == CH_NUL) skip_to_nul = 1'b0;
        end else if (num_active && is_digit) begin
            add_digit(4'(c - CH_ZERO));
        end else if (num_active && c == CH_DOT) begin
            // second dot freezes the number like atof does; later digits and dots are swallowed
            if (dot_seen) frac_frozen = 1'b1;
            else dot_seen = 1'b1;
        end else begin
            if (num_active) begin
                tk              = '0;
                tk.kind         = TK_NUMBER;
                tk.mantissa     = num_mant;
                tk.dec_exponent = EXP_W'(num_exp);
                tk.inexact      = num_inexact;
                toks.push_back(tk);
                clear_number();
            end
            if (is_digit) begin
                num_active = 1'b1;
                add_digit(4'(c - CH_ZERO));
            end else if (c != CH_SPACE) begin
                tk = '0;
                case (c)
                    CH_NUL:    tk.kind = TK_EOF;
                    CH_PLUS: begin
                        tk.kind        = TK_PLUS;
                        tk.left_power  = POW_ADD_L;
                        tk.right_power = POW_ADD_R;
                    end
                    CH_MINUS: begin
                        tk.kind        = TK_MINUS;
                        tk.left_power  = POW_ADD_L;
                        tk.right_power = POW_ADD_R;
                    end
                    CH_STAR: begin
                        tk.kind        = TK_MUL;
                        tk.left_power  = POW_MUL_L;
                        tk.right_power = POW_MUL_R;
                    end
                    CH_SLASH: begin
                        tk.kind        = TK_DIV;
                        tk.left_power  = POW_MUL_L;
                        tk.right_power = POW_MUL_R;
                    end
                    CH_LPAREN: tk.kind = TK_LPAREN;
                    CH_RPAREN: tk.kind = TK_RPAREN;
                    default: begin
                        tk.kind     = TK_INVALID;
                        skip_to_nul = 1'b1;
                    end
                endcase
                toks.push_back(tk);
            end
            if (toks.size() > 0) toks[toks.size()-1].last = 1'b1;
            foreach (toks[k]) tokens_due.push_back(toks[k]);
        end
    endtask

    task automatic check_token();
        t_token want;
        if (tokens_due.size() == 0) begin
            report_mismatch("arrived with none due, kind", 64'(i_token_kind), '0);
        end else begin
            want = tokens_due.pop_front();
            if (i_token_kind != want.kind)
                report_mismatch("kind", 64'(i_token_kind), 64'(want.kind));
            if (i_mantissa != want.mantissa)
                report_mismatch("mantissa", 64'(i_mantissa), 64'(want.mantissa));
            if (i_dec_exponent != want.dec_exponent)
                report_mismatch("exponent", 64'(i_dec_exponent), 64'(want.dec_exponent));
            if (i_inexact != want.inexact)
                report_mismatch("inexact", 64'(i_inexact), 64'(want.inexact));
            if (i_left_power != want.left_power)
                report_mismatch("left power", 64'(i_left_power), 64'(want.left_power));
            if (i_right_power != want.right_power)
                report_mismatch("right power", 64'(i_right_power), 64'(want.right_power));
            if (i_last != want.last)
                report_mismatch("last", 64'(i_last), 64'(want.last));
        end
        tokens_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_number();
            skip_to_nul = 1'b0;
            tokens_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) lex_char(i_char_code);
            if (i_out_valid && i_out_ready) check_token();
        end
        o_pending = tokens_due.size();
    end

endmodule

// ===== test/arith_expression_tokenizer_test.sv =====
// testbench top for the expression lexer: clock, reset, char stimulus, token stalls, verdict
`timescale 1ns / 100ps

module arith_expression_tokenizer_test;
    import aet_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int CHAR_TARGET = 1850;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [7:0]                i_char_code;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [KIND_W-1:0]         o_token_kind;
    logic [MANT_W-1:0]         o_mantissa;
    logic signed [EXP_W-1:0]   o_dec_exponent;
    logic                      o_inexact;
    logic [POW_W-1:0]          o_left_power;
    logic [POW_W-1:0]          o_right_power;
    logic                      o_last;

    int fail_count;
    int pending;
    int chars_sent;
    int burst_left;
    int idle_cycles;

    arith_expression_tokenizer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_mantissa     (o_mantissa),
        .o_dec_exponent (o_dec_exponent),
        .o_inexact      (o_inexact),
        .o_left_power   (o_left_power),
        .o_right_power  (o_right_power),
        .o_last         (o_last)
    );

    arith_expression_tokenizer_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_token_kind   (o_token_kind),
        .i_mantissa     (o_mantissa),
        .i_dec_exponent (o_dec_exponent),
        .i_inexact      (o_inexact),
        .i_left_power   (o_left_power),
        .i_right_power  (o_right_power),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // no word accepted on either side for too long means the block hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // token side: changing stall patterns plus two long hold-offs
    initial begin
        int mode;
        int span;
        int holds_done;
        i_out_ready = 1'b0;
        span        = 0;
        holds_done  = 0;
        forever begin
            @(negedge i_clk);
            if (holds_done < 2 && chars_sent >= 500 + holds_done * 800) begin
                i_out_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                holds_done++;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 80);
            end
            span--;
            case (mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 1) == 1);
                2:       i_out_ready <= ($urandom_range(0, 4) == 0);
                default: i_out_ready <= (span % 3 != 0);
            endcase
        end
    end

    // called at a falling edge, returns at the falling edge after the handshake
    task automatic send_char(input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        chars_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) send_char(s[k]);
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] rand_digit(input int lo);
        return 8'(CH_ZERO + $urandom_range(lo, 9));
    endfunction

    task automatic send_number();
        int len;
        int dot_at;
        int style;
        int k;
        logic [7:0] d;
        style = $urandom_range(0, 5);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
            6, 7, 8:          len = $urandom_range(5, 17);
            default:          len = $urandom_range(18, 26);
        endcase
        dot_at = ($urandom_range(0, 1) == 1) ? $urandom_range(1, len) : 0;
        for (k = 1; k <= len; k++) begin
            case (style)
                0:       d = CH_NINE;
                1:       d = ($urandom_range(0, 3) == 0) ? rand_digit(1) : CH_ZERO;
                default: d = rand_digit(0);
            endcase
            send_char(d);
            if (k == dot_at) send_char(CH_DOT);
        end
        // a second dot freezes the number, later digits and dots are swallowed
        if (dot_at != 0 && $urandom_range(0, 4) == 0) begin
            send_char(CH_DOT);
            repeat ($urandom_range(0, 4))
                send_char(($urandom_range(0, 3) == 0) ? CH_DOT : rand_digit(0));
        end
    endtask

    // long numbers that drive the exponent into saturation
    task automatic send_long_number(input logic upward);
        if (upward) begin
            send_char(rand_digit(1));
            repeat (150) send_char(rand_digit(0));
        end else begin
            send_char(CH_ZERO);
            send_char(CH_DOT);
            repeat (132) send_char(CH_ZERO);
            send_char(rand_digit(1));
        end
    endtask

    task automatic send_expression(input int long_kind);
        int terms;
        int t;
        terms = $urandom_range(1, 5);
        if ($urandom_range(0, 5) == 0) send_char(CH_MINUS);
        for (t = 0; t < terms; t++) begin
            if ($urandom_range(0, 3) == 0) send_char(CH_SPACE);
            if ($urandom_range(0, 3) == 0) send_char(CH_LPAREN);
            if (t == 0 && long_kind != 0) send_long_number(long_kind == 1);
            else send_number();
            if ($urandom_range(0, 3) == 0) send_char(CH_RPAREN);
            if ($urandom_range(0, 3) == 0) send_char(CH_SPACE);
            if (t < terms - 1) send_char(pick_operator());
        end
        send_char(CH_NUL);
    endtask

    // a bad char in an otherwise normal expression, then garbage up to nul
    task automatic send_broken();
        send_number();
        if ($urandom_range(0, 1) == 1) send_char(pick_operator());
        send_char(($urandom_range(0, 3) == 0) ? CH_DOT : 8'($urandom_range(8'h3A, 8'hFF)));
        repeat ($urandom_range(0, 5)) send_char(8'($urandom_range(1, 255)));
        send_char(CH_NUL);
    endtask

    initial begin
        int expr_idx;
        int pick;
        logic drained_mid;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_char_code = '0;
        chars_sent  = 0;
        burst_left  = 0;
        idle_cycles = 0;
        expr_idx    = 0;
        drained_mid = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every token kind but plus and invalid, leading zero, number closed by operator and by space
        send_text("0.25*(18-7)/9 ");
        send_char(CH_NUL);
        // second dot, then a dot with no number before it, then ignored input
        send_text("3.1.4+");
        send_char(CH_DOT);
        send_char(8'hFF);
        send_char(CH_NUL);
        pause_until_drained();

        while (chars_sent < CHAR_TARGET) begin
            if (!drained_mid && chars_sent >= 950) begin
                pause_until_drained();
                drained_mid = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (expr_idx % 80 == 25) send_expression(1 + (expr_idx / 80) % 2);
            else if (pick == 0) begin
                repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
                send_char(CH_NUL);
            end else if (pick == 1) send_broken();
            else send_expression(0);
            expr_idx++;
        end

        pause_until_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/aet_pkg.sv
hw/rtl/aet_front.sv
hw/rtl/aet_fifo.sv
hw/rtl/aet_back.sv
hw/rtl/arith_expression_tokenizer.sv
test/arith_expression_tokenizer_checker.sv
test/arith_expression_tokenizer_test.sv
